[rtl/core/htd_pkg.sv]
// ----------------------------------------------------------------------------
// htd_pkg
// Types, codes and the binding choice function of the hold-tap-dance decider.
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd16;
  localparam logic [4:0] MAX_BINDINGS = 5'd16;
  localparam logic [4:0] TAP_MAX = 5'd31;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic ACT_PRESS   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic REG_TERM   = 1'b0;
  localparam logic REG_BCOUNT = 1'b1;

  localparam logic [15:0] TERM_RESET   = 16'd200;
  localparam logic [4:0]  BCOUNT_RESET = 5'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  key_position;
    logic        is_dance_key;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  out_position;
    logic [3:0]  binding_index;
    logic [31:0] event_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        used;
    logic [7:0]  position;
    logic [4:0]  tap_count;
    logic        key_down;
    logic        decided;
    logic [3:0]  choice;
    logic [31:0] deadline;
    logic        armed;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PSCAN, ST_FIND, ST_UPD, ST_UPD2,
    ST_RSCAN, ST_TSCAN, ST_EP, ST_ER, ST_FIN
  } state_t;

  // even index = hold, odd = tap, clamped to the last index of that kind
  function automatic logic [3:0] choose_binding(input logic [4:0] tap,
                                                input logic       hold,
                                                input logic [4:0] bcount);
    logic [4:0] cnt;
    logic [4:0] tap_m1;
    logic [5:0] ix;
    logic [4:0] lastix;
    logic [3:0] res;
    if (bcount == 5'd0) cnt = 5'd1;
    else if (bcount > MAX_BINDINGS) cnt = MAX_BINDINGS;
    else cnt = bcount;
    tap_m1 = (tap == 5'd0) ? 5'd0 : tap - 5'd1;
    ix = {tap_m1, 1'b0} + {5'd0, ~hold};
    lastix = cnt - 5'd1;
    if (hold && lastix[0]) lastix = lastix - 5'd1;
    if (!hold && !lastix[0]) lastix = lastix - 5'd1;
    if (cnt == 5'd1) res = 4'd0;
    else if (ix >= {1'b0, cnt}) res = lastix[3:0];
    else res = ix[3:0];
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hold_tap_dance_key_decider_top.sv]
// ----------------------------------------------------------------------------
// hold_tap_dance_key_decider_top
// Hold-tap-dance decider: slot table, scan sequencer and result stage.
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer that walks the eight slots one
// per cycle, pausing while a result waits on the output, through a single
// compare and subtract unit. A tick or release takes at most one scan of the
// slots, a press a scan, a lookup scan and an update; each decided slot adds
// a step per result it emits, plus a closing step. A stalled output lengthens
// an item. in_ready is high only between items.
`default_nettype none

module hold_tap_dance_key_decider_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire htd_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output htd_pkg::out_item_t     out_item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import htd_pkg::*;

  logic [15:0] term;
  logic [4:0]  bcount;

  state_t          state, state_next;
  logic [IDX_W-1:0] idx;
  in_item_t        item;
  logic            found_v, free_v, is_new, from_tick;
  logic [IDX_W-1:0] found_idx, free_idx;
  logic [31:0]     dec_t;
  logic [3:0]      choice;
  logic [CNT_W-1:0] res_cnt;

  slot_t     e, wr_data;
  logic      wr_en;
  logic      push, push_ok, flush, flush_done, pend_valid;
  out_item_t push_item;

  logic        pos_match, at_last, expired, tscan_full;
  logic        pscan_hit, pscan_dec, rscan_hit, tscan_hit;
  logic [31:0] diff;
  logic [3:0]  choice_w;
  logic [4:0]  tap_base;
  state_t      after_dec;

  htd_table u_table (
    .clk(clk), .rst(rst), .idx(idx), .wr_en(wr_en), .wr_data(wr_data), .rd(e)
  );

  htd_outbuf u_outbuf (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .push_ok(push_ok),
    .flush(flush), .flush_done(flush_done), .pend_valid(pend_valid),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  assign in_ready   = (state == ST_IDLE);
  assign pos_match  = (e.position == item.key_position);
  assign at_last    = (idx == LAST_IDX);
  assign diff       = item.now_ms - e.deadline;
  assign expired    = !diff[31];
  assign tscan_full = (res_cnt > MAX_RESULTS - CNT_W'(2));
  assign pscan_hit  = e.used && !pos_match;
  assign pscan_dec  = pscan_hit && !e.decided;
  assign rscan_hit  = e.used && pos_match;
  assign tscan_hit  = e.used && e.armed && expired;
  assign choice_w   = choose_binding(e.tap_count, e.key_down, bcount);
  assign tap_base   = is_new ? 5'd0 : e.tap_count;

  always_comb begin
    if (from_tick) after_dec = at_last ? ST_FIN : ST_TSCAN;
    else after_dec = item.is_dance_key ? ST_FIND : ST_FIN;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (in_item.operation)
            OP_PRESS:   state_next = ST_PSCAN;
            OP_RELEASE: state_next = in_item.is_dance_key ? ST_RSCAN : ST_FIN;
            OP_TICK:    state_next = ST_TSCAN;
            default:    state_next = ST_FIN;
          endcase
        end
      end
      ST_PSCAN: begin
        if (pscan_dec) state_next = ST_EP;
        else if (at_last) state_next = item.is_dance_key ? ST_FIND : ST_FIN;
      end
      ST_EP: begin
        if (push_ok) state_next = e.key_down ? after_dec : ST_ER;
      end
      ST_ER: begin
        if (push_ok) state_next = after_dec;
      end
      ST_FIND: begin
        if (at_last) state_next = ST_UPD;
      end
      ST_UPD:  state_next = (found_v || free_v) ? ST_UPD2 : ST_FIN;
      ST_UPD2: state_next = ST_FIN;
      ST_RSCAN: begin
        if (rscan_hit) begin
          if (!e.decided || push_ok) state_next = ST_FIN;
        end else if (at_last) begin
          state_next = ST_FIN;
        end
      end
      ST_TSCAN: begin
        if (tscan_hit) state_next = tscan_full ? ST_FIN : ST_EP;
        else if (at_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (flush_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // table writes and result pushes
  always_comb begin
    wr_en     = 1'b0;
    wr_data   = e;
    push      = 1'b0;
    flush     = 1'b0;
    push_item = '{action: ACT_PRESS, out_position: e.position, binding_index: choice,
                  event_time: dec_t, last: 1'b0};
    unique case (state)
      ST_PSCAN: begin
        if (pscan_hit) begin
          wr_en         = 1'b1;
          wr_data.armed = 1'b0;
          if (!e.decided) begin
            wr_data.decided = 1'b1;
            wr_data.choice  = choice_w;
          end
        end
      end
      ST_EP: push = 1'b1;
      ST_ER: begin
        push             = 1'b1;
        push_item.action = ACT_RELEASE;
        wr_en            = push_ok;
        wr_data.used     = 1'b0;
      end
      ST_UPD2: begin
        wr_en = 1'b1;
        if (is_new) begin
          wr_data.used     = 1'b1;
          wr_data.position = item.key_position;
          wr_data.decided  = 1'b0;
          wr_data.choice   = 4'd0;
        end
        wr_data.key_down  = 1'b1;
        wr_data.tap_count = (tap_base == TAP_MAX) ? TAP_MAX : tap_base + 5'd1;
        wr_data.deadline  = item.now_ms + {16'd0, term};
        wr_data.armed     = 1'b1;
      end
      ST_RSCAN: begin
        if (rscan_hit) begin
          wr_data.key_down = 1'b0;
          if (e.decided) begin
            push                    = 1'b1;
            push_item.action        = ACT_RELEASE;
            push_item.binding_index = e.choice;
            push_item.event_time    = item.now_ms;
            wr_en                   = push_ok;
            wr_data.used            = 1'b0;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      ST_TSCAN: begin
        if (tscan_hit && !tscan_full) begin
          wr_en           = 1'b1;
          wr_data.armed   = 1'b0;
          wr_data.decided = 1'b1;
          wr_data.choice  = choice_w;
        end
      end
      ST_FIN: flush = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      term   <= TERM_RESET;
      bcount <= BCOUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TERM:   term   <= cfg_data;
          REG_BCOUNT: bcount <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ok) res_cnt <= res_cnt + CNT_W'(1);
    unique case (state)
      ST_IDLE: begin
        item    <= in_item;
        idx     <= '0;
        res_cnt <= '0;
      end
      ST_PSCAN: begin
        if (pscan_dec) begin
          choice    <= choice_w;
          dec_t     <= item.now_ms;
          from_tick <= 1'b0;
        end else begin
          idx     <= idx + IDX_W'(1);
          found_v <= 1'b0;
          free_v  <= 1'b0;
        end
      end
      ST_EP, ST_ER: begin
        // leave the decision: carry on the tick scan or restart for the lookup
        if (state_next != ST_EP && state_next != ST_ER) begin
          if (from_tick) begin
            idx <= idx + IDX_W'(1);
          end else begin
            idx     <= '0;
            found_v <= 1'b0;
            free_v  <= 1'b0;
          end
        end
      end
      ST_FIND: begin
        if (rscan_hit && !found_v) begin
          found_v   <= 1'b1;
          found_idx <= idx;
        end
        if (!e.used && !free_v) begin
          free_v   <= 1'b1;
          free_idx <= idx;
        end
        idx <= idx + IDX_W'(1);
      end
      ST_UPD: begin
        idx    <= found_v ? found_idx : free_idx;
        is_new <= !found_v;
      end
      ST_RSCAN: begin
        if (!rscan_hit) idx <= idx + IDX_W'(1);
      end
      ST_TSCAN: begin
        if (tscan_hit) begin
          choice    <= choice_w;
          dec_t     <= e.deadline;
          from_tick <= 1'b1;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("pending result left over between items");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second item without processing the first");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= MAX_RESULTS)
    else $error("more results than allowed for one item");

  a_push_only_busy: assert property (@(posedge clk) disable iff (rst)
    push |-> !in_ready)
    else $error("result produced while idle");

endmodule

`default_nettype wire

[rtl/core/htd_table.sv]
// ----------------------------------------------------------------------------
// htd_table
// Slot table: one entry read and written at the scan index, used bits reset.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_table (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [htd_pkg::IDX_W-1:0] idx,
  input  wire logic                  wr_en,
  input  wire htd_pkg::slot_t        wr_data,
  output htd_pkg::slot_t             rd
);
  import htd_pkg::*;

  logic [SLOTS-1:0] used;
  slot_t            entry [SLOTS];

  always_comb begin
    rd      = entry[idx];
    rd.used = used[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en) begin
      used[idx] <= wr_data.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[idx] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/htd_outbuf.sv]
// ----------------------------------------------------------------------------
// htd_outbuf
// Result stage: holds one pending item so the final one can be marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_outbuf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire htd_pkg::out_item_t push_item,
  output logic                    push_ok,
  input  wire logic               flush,
  output logic                    flush_done,
  output logic                    pend_valid,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output htd_pkg::out_item_t      out_item
);
  import htd_pkg::*;

  out_item_t pend;
  logic      out_free;

  assign out_free   = !out_valid || out_ready;
  assign push_ok    = !pend_valid || out_free;
  assign flush_done = !pend_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (push && push_ok) begin
      if (pend_valid) begin
        out_item  <= '{action: pend.action, out_position: pend.out_position,
                       binding_index: pend.binding_index,
                       event_time: pend.event_time, last: 1'b0};
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      pend       <= push_item;
      pend_valid <= 1'b1;
    end else if (flush && pend_valid && out_free) begin
      // final item of this input: release it marked last
      out_item   <= '{action: pend.action, out_position: pend.out_position,
                      binding_index: pend.binding_index,
                      event_time: pend.event_time, last: 1'b1};
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sim/htd_result_checker.sv]
// ----------------------------------------------------------------------------
// htd_result_checker
// Watches the item, result and register ports of the hold-tap-dance decider,
// keeps its own copy of the slot table and the registers, works out the
// results of every accepted item and compares each result with the oldest
// one still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_result_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire htd_pkg::in_item_t  in_item,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire htd_pkg::out_item_t out_item,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      errors,
  output int                      pending
);
  import htd_pkg::*;

  localparam int NSLOT = 8;

  logic [15:0] term;
  logic [4:0]  bcount;

  logic        s_used    [NSLOT];
  logic [7:0]  s_pos     [NSLOT];
  logic [4:0]  s_taps    [NSLOT];
  logic        s_down    [NSLOT];
  logic        s_decided [NSLOT];
  logic [3:0]  s_choice  [NSLOT];
  logic [31:0] s_dead    [NSLOT];
  logic        s_armed   [NSLOT];

  out_item_t owed_results[$];
  out_item_t batch[$];

  assign pending = owed_results.size();

  function automatic logic [3:0] pick_binding(int n);
    int cnt;
    int ix;
    bit hold;
    cnt = bcount;
    hold = s_down[n];
    if (cnt == 0) cnt = 1;
    if (cnt > 16) cnt = 16;
    if (cnt == 1) return 4'd0;
    ix = ((s_taps[n] > 0) ? s_taps[n] - 1 : 0) * 2;
    if (!hold) ix++;
    if (ix >= cnt) begin
      ix = cnt - 1;
      if (hold && ix[0]) ix--;
      if (!hold && !ix[0]) ix--;
    end
    return ix[3:0];
  endfunction

  task automatic add_result(logic act, logic [7:0] p, logic [3:0] ix, logic [31:0] t);
    out_item_t r;
    if (batch.size() >= 16) return;
    r.action = act;
    r.out_position = p;
    r.binding_index = ix;
    r.event_time = t;
    r.last = 1'b0;
    batch.push_back(r);
  endtask

  task automatic settle_slot(int n, logic [31:0] t);
    s_armed[n] = 1'b0;
    s_decided[n] = 1'b1;
    s_choice[n] = pick_binding(n);
    add_result(ACT_PRESS, s_pos[n], s_choice[n], t);
    if (!s_down[n]) begin
      add_result(ACT_RELEASE, s_pos[n], s_choice[n], t);
      s_used[n] = 1'b0;
    end
  endtask

  task automatic predict_item(in_item_t it);
    int hit;
    logic [31:0] diff;
    batch.delete();
    if (it.operation == OP_PRESS) begin
      for (int n = 0; n < NSLOT; n++) begin
        if (!s_used[n] || s_pos[n] == it.key_position) continue;
        s_armed[n] = 1'b0;
        if (!s_decided[n]) begin
          settle_slot(n, it.now_ms);
          break;
        end
      end
      if (it.is_dance_key) begin
        hit = -1;
        for (int n = 0; n < NSLOT; n++)
          if (hit < 0 && s_used[n] && s_pos[n] == it.key_position) hit = n;
        for (int n = 0; n < NSLOT; n++)
          if (hit < 0 && !s_used[n]) begin
            hit = n;
            s_used[n] = 1'b1;
            s_pos[n] = it.key_position;
            s_taps[n] = '0;
            s_decided[n] = 1'b0;
            s_choice[n] = '0;
          end
        if (hit >= 0) begin
          s_down[hit] = 1'b1;
          if (s_taps[hit] < 5'd31) s_taps[hit]++;
          s_dead[hit] = it.now_ms + {16'd0, term};
          s_armed[hit] = 1'b1;
        end
      end
    end else if (it.operation == OP_RELEASE) begin
      if (it.is_dance_key)
        for (int n = 0; n < NSLOT; n++) begin
          if (!s_used[n] || s_pos[n] != it.key_position) continue;
          s_down[n] = 1'b0;
          if (s_decided[n]) begin
            add_result(ACT_RELEASE, s_pos[n], s_choice[n], it.now_ms);
            s_used[n] = 1'b0;
          end
          break;
        end
    end else if (it.operation == OP_TICK) begin
      for (int n = 0; n < NSLOT; n++) begin
        if (!s_used[n] || !s_armed[n]) continue;
        diff = it.now_ms - s_dead[n];
        if (diff[31]) continue;
        if (batch.size() > 14) break;
        settle_slot(n, s_dead[n]);
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) owed_results.push_back(batch[k]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      term = TERM_RESET;
      bcount = BCOUNT_RESET;
      for (int n = 0; n < NSLOT; n++) begin
        s_used[n] = 1'b0;
        s_pos[n] = '0;
        s_taps[n] = '0;
        s_down[n] = 1'b0;
        s_decided[n] = 1'b0;
        s_choice[n] = '0;
        s_dead[n] = '0;
        s_armed[n] = 1'b0;
      end
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TERM) term = cfg_data;
        else bcount = cfg_data[4:0];
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result, position", out_item.out_position, 0);
        end else begin
          want = owed_results.pop_front();
          if (out_item.action !== want.action)
            report_mismatch("action", out_item.action, want.action);
          if (out_item.out_position !== want.out_position)
            report_mismatch("out_position", out_item.out_position, want.out_position);
          if (out_item.binding_index !== want.binding_index)
            report_mismatch("binding_index", out_item.binding_index, want.binding_index);
          if (out_item.event_time !== want.event_time)
            report_mismatch("event_time", out_item.event_time, want.event_time);
          if (out_item.last !== want.last)
            report_mismatch("last", out_item.last, want.last);
        end
      end
      if (in_valid && in_ready) predict_item(in_item);
    end
  end

endmodule

`default_nettype wire

[sim/tb_hold_tap_dance_key_decider_top.sv]
// ----------------------------------------------------------------------------
// tb_hold_tap_dance_key_decider_top
// Drives presses, releases and ticks into the hold-tap-dance decider under
// several register settings, with random gaps and output stalls; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hold_tap_dance_key_decider_top;
  import htd_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;

  int          cycles;
  bit          calm;        // no idling on either side
  bit          stall_req;
  bit          stall_seen;
  int          stall_left;
  logic [31:0] clock_ms;
  logic [15:0] cur_term;

  hold_tap_dance_key_decider_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  htd_result_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_req && !stall_seen) begin
      stall_left = 300;
      stall_seen = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] p, logic dance, logic [31:0] t);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 50) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{operation: op, key_position: p, is_dance_key: dance, now_ms: t};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_TERM) cur_term = val;
  endtask

  // mostly well-formed dance traffic on a few keys, some noise
  task automatic random_item();
    int r;
    logic [31:0] step;
    r = $urandom_range(99);
    step = $urandom_range(0, 32'(cur_term) + 40);
    if (r < 15) begin
      send(2'($urandom_range(3)), 8'($urandom), 1'($urandom), $urandom);
    end else begin
      clock_ms = clock_ms + step / 2;
      if (r < 50)
        send(OP_PRESS, 8'(40 + $urandom_range(9)), $urandom_range(9) != 0, clock_ms);
      else if (r < 75)
        send(OP_RELEASE, 8'(40 + $urandom_range(9)), $urandom_range(9) != 0, clock_ms);
      else
        send(OP_TICK, 8'($urandom), 1'($urandom), clock_ms + step);
    end
  endtask

  initial begin
    logic [15:0] terms [7];
    logic [4:0]  counts [7];
    terms  = '{16'd200, 16'd0, 16'd65535, 16'd37, 16'd5, 16'd1, 16'd300};
    counts = '{5'd2, 5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd4};
    calm = 1'b0;
    stall_req = 1'b0;
    cur_term = TERM_RESET;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TERM;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tap, hold, interrupts, full table, odd items, wrap
    send(OP_PRESS,   8'd5,   1'b1, 32'd100);
    send(OP_RELEASE, 8'd5,   1'b1, 32'd150);
    send(OP_TICK,    8'd0,   1'b0, 32'd300);
    send(OP_PRESS,   8'd5,   1'b1, 32'd400);
    send(OP_TICK,    8'd0,   1'b0, 32'd700);
    send(OP_PRESS,   8'd5,   1'b1, 32'd710);
    send(OP_TICK,    8'd0,   1'b0, 32'd1000);
    send(OP_RELEASE, 8'd5,   1'b1, 32'd1010);
    send(OP_PRESS,   8'd9,   1'b0, 32'd1020);
    send(OP_RELEASE, 8'd77,  1'b1, 32'd1030);
    send(OP_RELEASE, 8'd9,   1'b0, 32'd1040);
    send(2'd3,       8'd255, 1'b1, 32'hFFFF_FFFF);
    for (int k = 0; k < 9; k++)
      send(OP_PRESS, (k == 0) ? 8'd255 : 8'(k), 1'b1, 32'hFFFF_FF80 + k);
    send(OP_TICK,    8'd0,   1'b0, 32'h0000_2000);
    send(OP_TICK,    8'd0,   1'b0, 32'h0000_2001);
    for (int k = 0; k < 9; k++)
      send(OP_RELEASE, (k == 0) ? 8'd255 : 8'(k), 1'b1, 32'h0000_3000);
    drain();

    clock_ms = 32'hFFFF_0000;
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_TERM, terms[ph]);
      write_reg(REG_BCOUNT, {11'd0, counts[ph]});
      calm = (ph == 2);
      for (int k = 0; k < 15; k++) begin
        if (ph == 3 && k == 5) stall_req = 1'b1;
        random_item();
      end
      // release keys 40 to 48, then let a late tick settle the rest
      for (int k = 0; k < 9; k++) send(OP_RELEASE, 8'(40 + k), 1'b1, clock_ms);
      send(OP_TICK, 8'd0, 1'b0, clock_ms + 32'h0002_0000);
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/htd_pkg.sv
rtl/core/htd_table.sv
rtl/core/htd_outbuf.sv
rtl/core/hold_tap_dance_key_decider_top.sv
sim/htd_result_checker.sv
sim/tb_hold_tap_dance_key_decider_top.sv
